// ===== rtl/swrl_pkg.sv =====
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared types and codes for the sliding window rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;

  localparam int TIME_W    = 48;
  localparam int MAXW_W    = 7;
  localparam int MININT_W  = 16;
  localparam int REASON_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [MAXW_W-1:0] MAXW_RESET = 7'd10;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE     = 2'd0,
    RSN_INTERVAL = 2'd1,
    RSN_BUDGET   = 2'd2
  } reason_t;

  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic {
    REG_MAX_PER_WINDOW  = 1'b0,
    REG_MIN_INTERVAL_MS = 1'b1
  } reg_idx_t;

endpackage

// ===== rtl/sliding_window_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Admits or refuses timestamped requests against a per-window budget and a
// minimum spacing, keeping recent admission times in a circular log.
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat taken when
//  --------+-----------------------------------------+-----------------------
//  in      | in_operation, in_now_ms, in_exempt      | in_valid & !in_stall
//  out     | out_admitted, out_reason, out_count_... | out_valid & !out_stall
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata | psel & penable & pwrite
//
//  A clear or exempt request goes from ST_IDLE to ST_RESP; an ordinary one runs
//  ST_FETCH and ST_CMP for each expired time dropped and for the first kept,
//  then ST_CHECK, or ST_FETCH to ST_CHECK when the log is empty after pruning;
//  the single time subtractor and registered log read need both steps per entry.
//  in_stall is high while a request is in flight. A result waits in the
//  output register while out_stall is high; a request finishing then holds.
//  Reset (synchronous, rst_n low) empties the log; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter #(
  parameter int FIFO_DEPTH = 64,
  parameter int WINDOW_MS  = 60000
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [swrl_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                            in_exempt,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_admitted,
  output logic [swrl_pkg::REASON_W-1:0]   out_reason,
  output logic [swrl_pkg::COUNT_W-1:0]    out_count_in_window,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swrl_pkg::APB_AW-1:0]     paddr,
  input  logic [swrl_pkg::APB_DW-1:0]     pwdata,
  output logic [swrl_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import swrl_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int BW = ((CW > MAXW_W) ? CW : MAXW_W) + 1;
  localparam logic [AW-1:0]     LAST_IDX = AW'(FIFO_DEPTH - 1);
  localparam logic [BW-1:0]     DEPTH_B  = BW'(FIFO_DEPTH);
  localparam logic [TIME_W-1:0] WIN      = TIME_W'(WINDOW_MS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_FETCH,
    ST_CMP,
    ST_CHECK
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       head_r;
  logic [AW-1:0]       tail_r;
  logic [CW-1:0]       count_r;
  logic [TIME_W-1:0]   last_time_r;
  logic                last_valid_r;
  logic [MAXW_W-1:0]   max_per_window_r;
  logic [MININT_W-1:0] min_interval_ms_r;
  logic [TIME_W-1:0]   now_r;
  logic                clear_r;

  logic                out_valid_r;
  logic                out_admitted_r;
  reason_t             out_reason_r;
  logic [COUNT_W-1:0]  out_count_r;

  // admission log
  logic [TIME_W-1:0]   log_mem [FIFO_DEPTH];
  logic [TIME_W-1:0]   rd_data_r;
  logic                log_wr;

  // shared subtractor
  logic [TIME_W-1:0]   sub_b;
  logic [TIME_W:0]     diff;
  logic                is_old;
  logic                too_soon;
  logic [BW-1:0]       max_b;
  logic [BW-1:0]       budget;
  logic                full;
  logic                out_free;
  logic                cfg_wr;
  logic                in_take;

  assign sub_b  = (state_r == ST_CMP) ? rd_data_r : last_time_r;
  assign diff   = {1'b0, now_r} - {1'b0, sub_b};
  assign is_old = !diff[TIME_W] && (diff[TIME_W-1:0] >= WIN);
  assign too_soon = last_valid_r &&
                    (diff[TIME_W] ||
                     (diff[TIME_W-1:0] < TIME_W'(min_interval_ms_r)));

  assign max_b  = BW'(max_per_window_r);
  assign budget = (max_b == '0) ? BW'(1) : ((max_b > DEPTH_B) ? DEPTH_B : max_b);
  assign full   = BW'(count_r) >= budget;

  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign log_wr   = (state_r == ST_CHECK) && out_free && !too_soon && !full;

  always_ff @(posedge clk) begin
    if (log_wr) begin
      log_mem[tail_r] <= now_r;
    end
    if (state_r == ST_FETCH) begin
      rd_data_r <= log_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      head_r            <= '0;
      tail_r            <= '0;
      count_r           <= '0;
      last_time_r       <= '0;
      last_valid_r      <= 1'b0;
      max_per_window_r  <= MAXW_RESET;
      min_interval_ms_r <= '0;
      clear_r           <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        if (reg_idx_t'(paddr[2]) == REG_MAX_PER_WINDOW) begin
          max_per_window_r <= pwdata[MAXW_W-1:0];
        end else begin
          min_interval_ms_r <= pwdata[MININT_W-1:0];
        end
        head_r       <= '0;
        tail_r       <= '0;
        count_r      <= '0;
        last_time_r  <= '0;
        last_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            now_r   <= in_now_ms;
            clear_r <= (op_t'(in_operation) == OP_CLEAR);
            if (op_t'(in_operation) == OP_CLEAR) begin
              head_r       <= '0;
              tail_r       <= '0;
              count_r      <= '0;
              last_time_r  <= '0;
              last_valid_r <= 1'b0;
              state_r      <= ST_RESP;
            end else if (in_exempt) begin
              state_r <= ST_RESP;
            end else begin
              state_r <= ST_FETCH;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_admitted_r <= 1'b1;
            out_reason_r   <= RSN_NONE;
            out_count_r    <= clear_r ? '0 : COUNT_W'(count_r);
            state_r        <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          state_r <= (count_r == '0) ? ST_CHECK : ST_CMP;
        end
        ST_CMP: begin
          if (is_old) begin
            head_r  <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_r <= count_r - 1'b1;
            state_r <= ST_FETCH;
          end else begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (too_soon) begin
              out_admitted_r <= 1'b0;
              out_reason_r   <= RSN_INTERVAL;
              out_count_r    <= COUNT_W'(count_r);
            end else if (full) begin
              out_admitted_r <= 1'b0;
              out_reason_r   <= RSN_BUDGET;
              out_count_r    <= COUNT_W'(count_r);
            end else begin
              out_admitted_r <= 1'b1;
              out_reason_r   <= RSN_NONE;
              out_count_r    <= COUNT_W'(count_r + 1'b1);
              tail_r         <= (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
              count_r        <= count_r + 1'b1;
              last_time_r    <= now_r;
              last_valid_r   <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (reg_idx_t'(paddr[2]) == REG_MAX_PER_WINDOW) begin
      prdata = APB_DW'(max_per_window_r);
    end else begin
      prdata = APB_DW'(min_interval_ms_r);
    end
  end

  assign pready              = 1'b1;
  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_admitted        = out_admitted_r;
  assign out_reason          = out_reason_r;
  assign out_count_in_window = out_count_r;

endmodule
